// ----- sv/olst_pkg.sv -----
// Package for the ordered list store: sizes, request and status codes,
// and the per-cell control struct. No dependencies.
`default_nettype none

package olst_pkg;

   localparam int CAPACITY   = 16;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int LEN_BITS   = 5;
   localparam int TYPE_BITS  = 2;
   localparam int STAT_BITS  = 2;

   typedef logic [LEN_BITS-1:0]   len_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [TYPE_BITS-1:0]  kind_type;
   typedef logic [STAT_BITS-1:0]  stat_type;

   localparam kind_type REQ_INSERT = 2'd0;
   localparam kind_type REQ_REMOVE = 2'd1;
   localparam kind_type REQ_FIND   = 2'd2;
   localparam kind_type REQ_CLEAR  = 2'd3;

   localparam stat_type ST_DONE      = 2'd0;
   localparam stat_type ST_BAD       = 2'd1;
   localparam stat_type ST_FULL      = 2'd2;
   localparam stat_type ST_NOT_FOUND = 2'd3;

   localparam len_type CAPACITY_LEN = len_type'(CAPACITY);

   typedef struct packed {
      logic load_value;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- sv/olst_ifs.sv -----
// Request and response channel interfaces for the ordered list store.
// Depends on olst_pkg.
`default_nettype none

interface olst_req_if;
   logic                  valid;
   logic                  ready;
   olst_pkg::kind_type    req_type;
   logic [4:0]            position;
   logic [4:0]            run_count;
   logic [31:0]           value;

   modport source (output valid, req_type, position, run_count, value, input ready);
   modport sink   (input valid, req_type, position, run_count, value, output ready);
endinterface

interface olst_rsp_if;
   logic                  valid;
   logic                  ready;
   olst_pkg::stat_type    status;
   logic [3:0]            found_position;
   logic [4:0]            list_length;

   modport source (output valid, status, found_position, list_length, input ready);
   modport sink   (input valid, status, found_position, list_length, output ready);
endinterface

`default_nettype wire

// ----- sv/olst_cell.sv -----
// One storage cell of the list chain: holds one entry, loads a new value
// or takes a neighbor's entry, and compares its entry to the search key.
// Depends on olst_pkg.
`default_nettype none

module olst_cell (
   input  wire                     clock,
   input  olst_pkg::cell_ctrl_type ctrl,
   input  olst_pkg::value_type     value,
   input  olst_pkg::value_type     left_data,
   input  olst_pkg::value_type     right_data,
   output olst_pkg::value_type     data,
   output logic                    match
);

   olst_pkg::value_type entry_ff;
   olst_pkg::value_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_value) begin
         entry_in = value;
      end else if (ctrl.take_left) begin
         entry_in = left_data;
      end else if (ctrl.take_right) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data  = entry_ff;
   assign match = (entry_ff == value);

endmodule

`default_nettype wire

// ----- sv/ordered_list_store_core.sv -----
// Ordered list store: top level with request decode, the cell chain and
// the response register. Depends on olst_pkg, olst_ifs and olst_cell.
//
// Usage: requests arrive on req (insert, remove run, find, clear); each
// gives exactly one item on rsp with status, found position and the list
// length after the request. An item is taken when valid and ready are high.
// Response: registered; it shows in the cycle after accept.
// Flow: insert, find and clear complete at accept; an insert moves
// every later cell up one place in the same cycle, and find compares all
// cells at once. A remove of N entries enters S_SHIFT: the chain moves
// the tail down one place per cycle, and no request is taken meanwhile
// (its response is already out).
// Reset: synchronous, active high; the list becomes empty and the
// response register empties. Cell contents are not cleared.
// Stall: while rsp is held off, the response holds; one more request is
// taken only when the response register drains in the same cycle.
`default_nettype none

module ordered_list_store_core (
   input  wire         clock,
   input  wire         reset,
   olst_req_if.sink    req,
   olst_rsp_if.source  rsp
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_SHIFT = 1'b1;

   logic                state_ff, state_in;
   olst_pkg::len_type   used_ff, used_in;
   olst_pkg::len_type   shift_pos_ff, shift_pos_in;
   olst_pkg::len_type   shift_left_ff, shift_left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   olst_pkg::stat_type  status_ff, status_in;
   olst_pkg::idx_type   found_ff, found_in;
   olst_pkg::len_type   length_ff, length_in;

   olst_pkg::cell_ctrl_type ctrl   [olst_pkg::CAPACITY];
   olst_pkg::value_type     data   [olst_pkg::CAPACITY];
   olst_pkg::value_type     left_d [olst_pkg::CAPACITY];
   olst_pkg::value_type     right_d[olst_pkg::CAPACITY];
   logic [olst_pkg::CAPACITY-1:0] match;
   logic [olst_pkg::CAPACITY-1:0] hit;

   logic                accept;
   logic [olst_pkg::LEN_BITS:0] run_end;
   logic                hit_any;
   olst_pkg::idx_type   hit_idx;
   logic                insert_ok;

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign run_end   = {1'b0, req.position} + {1'b0, req.run_count};
   assign insert_ok = (req.position <= used_ff) && (used_ff != olst_pkg::CAPACITY_LEN);

   genvar g;
   generate
      for (g = 0; g < olst_pkg::CAPACITY; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign left_d[g] = '0;
         end else begin : g_mid_l
            assign left_d[g] = data[g-1];
         end
         if (g == olst_pkg::CAPACITY - 1) begin : g_last
            assign right_d[g] = '0;
         end else begin : g_mid_r
            assign right_d[g] = data[g+1];
         end
         olst_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl[g]),
            .value      (olst_pkg::value_type'(req.value)),
            .left_data  (left_d[g]),
            .right_data (right_d[g]),
            .data       (data[g]),
            .match      (match[g])
         );
      end
   endgenerate

   // lowest matching live position
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < olst_pkg::CAPACITY; i++) begin
         hit[i] = match[i] && (olst_pkg::len_type'(i) < used_ff);
      end
      for (int i = olst_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_any = 1'b1;
            hit_idx = olst_pkg::idx_type'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < olst_pkg::CAPACITY; i++) begin
         ctrl[i] = '0;
      end
      if (state_ff == S_SHIFT) begin
         for (int i = 0; i < olst_pkg::CAPACITY; i++) begin
            ctrl[i].take_right = (olst_pkg::len_type'(i) >= shift_pos_ff);
         end
      end else if (accept && (req.req_type == olst_pkg::REQ_INSERT) && insert_ok) begin
         for (int i = 0; i < olst_pkg::CAPACITY; i++) begin
            ctrl[i].load_value = (olst_pkg::len_type'(i) == req.position);
            ctrl[i].take_left  = (olst_pkg::len_type'(i) >  req.position);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      shift_pos_in  = shift_pos_ff;
      shift_left_in = shift_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      status_in     = status_ff;
      found_in      = found_ff;
      length_in     = length_ff;

      if (state_ff == S_SHIFT) begin
         shift_left_in = shift_left_ff - 1'b1;
         if (shift_left_ff == olst_pkg::len_type'(1)) begin
            state_in = S_IDLE;
         end
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = olst_pkg::ST_DONE;
         found_in     = '0;
         case (req.req_type)
            olst_pkg::REQ_INSERT: begin
               if (req.position > used_ff) begin
                  status_in = olst_pkg::ST_BAD;
               end else if (used_ff == olst_pkg::CAPACITY_LEN) begin
                  status_in = olst_pkg::ST_FULL;
               end else begin
                  used_in = used_ff + 1'b1;
               end
            end
            olst_pkg::REQ_REMOVE: begin
               if (run_end > {1'b0, used_ff}) begin
                  status_in = olst_pkg::ST_BAD;
               end else begin
                  used_in = used_ff - req.run_count;
                  if (req.run_count != '0) begin
                     state_in      = S_SHIFT;
                     shift_pos_in  = req.position;
                     shift_left_in = req.run_count;
                  end
               end
            end
            olst_pkg::REQ_FIND: begin
               if (hit_any) begin
                  found_in = hit_idx;
               end else begin
                  status_in = olst_pkg::ST_NOT_FOUND;
               end
            end
            olst_pkg::REQ_CLEAR: begin
               used_in = '0;
            end
            default: begin
               status_in = olst_pkg::ST_BAD;
            end
         endcase
         length_in = used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_pos_ff  <= shift_pos_in;
      shift_left_ff <= shift_left_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      length_ff     <= length_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.found_position = found_ff;
   assign rsp.list_length    = length_ff;

endmodule

`default_nettype wire

// ----- sv/olst_checker.sv -----
// Port-level checks for the ordered list store and their bind to the top.
// Depends on olst_pkg and ordered_list_store_core.
`default_nettype none

module olst_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input olst_pkg::kind_type  req_type,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input olst_pkg::stat_type  status,
   input olst_pkg::idx_type   found_position,
   input olst_pkg::len_type   list_length
);

   logic accept;
   assign accept = req_valid && req_ready;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("no item on rsp after an accepted request");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == olst_pkg::REQ_CLEAR) |=>
         (status == olst_pkg::ST_DONE) && (list_length == '0))
      else $error("clear did not leave an empty list");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == olst_pkg::ST_FULL) |->
         (list_length == olst_pkg::CAPACITY_LEN))
      else $error("full status with list not at capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
         && $stable(found_position) && $stable(list_length))
      else $error("stalled rsp item changed");

endmodule

bind ordered_list_store_core olst_checker u_olst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_type       (req.req_type),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .status         (rsp.status),
   .found_position (rsp.found_position),
   .list_length    (rsp.list_length)
);

`default_nettype wire
